// ===== rtl/core/fat12_pkg.sv =====
// Shared types, codes and constants for the FAT12 table engine.
package fat12_pkg;

  // Default sizes
  localparam int TABLE_BYTES_DEF  = 8192;
  localparam int SECTOR_BYTES_DEF = 512;

  // Field widths
  localparam int FUNC_W  = 3;
  localparam int ENTRY_W = 12;
  localparam int BADDR_W = 13;
  localparam int LIMIT_W = 13;
  localparam int COUNT_W = 13;

  // Entry codes
  localparam logic [ENTRY_W-1:0] EOC_LOW  = 12'hFF8;
  localparam logic [ENTRY_W-1:0] EOC_CODE = 12'hFFF;

  // Cluster limit register
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4086;
  localparam logic [LIMIT_W-1:0] INDEX_SPAN  = 13'd4096;
  localparam logic               REG_CLUSTER_LIMIT = 1'b0;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_FIND  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_COUNT = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the input item, reset scan state
    logic load_wr;   // write the loaded byte
    logic wr_lo;     // write the first byte of the entry
    logic wr_hi;     // write the second byte of the entry
    logic scan;      // advance the scan pipeline
    logic done;      // register the result and strobe it
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic hit;         // scanned entry is free
    logic scan_empty;  // nothing left to issue and pipeline drained
  } stat_t;

endpackage

// ===== rtl/core/fat12_table_engine_core.sv =====
// Top level of the FAT12 table engine: register port, controller and datapath.
//
//  channel   | transfer when                       | payload
//  ----------+-------------------------------------+-----------------------------------
//  input     | start && !busy                      | in_func, in_cluster, in_value,
//            |                                     | in_byte_address, in_byte_data
//  result    | out_valid (one cycle, no stall)     | out_next_cluster .. out_sector_count
//  register  | psel && penable && pwrite && pready | pwdata[12:0] -> cluster_limit
//
// After the transfer a read issues the address, then decodes the entry; a write reads,
// then writes both bytes; find and count read one entry per cycle from the dual
// read port table memory. busy is high from the cycle after the transfer until
// the cycle that shows the result. Reset (synchronous, active low) returns the
// controller to idle and the limit to 4086; the table holds no reset value.
// The result receiver cannot stall: each result shows for exactly one cycle.
module fat12_table_engine_core #(
  parameter int TABLE_BYTES  = fat12_pkg::TABLE_BYTES_DEF,
  parameter int SECTOR_BYTES = fat12_pkg::SECTOR_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // input channel
  input  logic                          start,
  output logic                          busy,
  input  logic [fat12_pkg::FUNC_W-1:0]  in_func,
  input  logic [fat12_pkg::ENTRY_W-1:0] in_cluster,
  input  logic [fat12_pkg::ENTRY_W-1:0] in_value,
  input  logic [fat12_pkg::BADDR_W-1:0] in_byte_address,
  input  logic [7:0]                    in_byte_data,
  // result channel
  output logic                          out_valid,
  output logic [fat12_pkg::ENTRY_W-1:0] out_next_cluster,
  output logic                          out_end_of_chain,
  output logic [fat12_pkg::ENTRY_W-1:0] out_found_cluster,
  output logic [fat12_pkg::COUNT_W-1:0] out_free_count,
  output logic                          out_status,
  output logic [3:0]                    out_sector_index,
  output logic [1:0]                    out_sector_count
);

  logic [fat12_pkg::LIMIT_W-1:0] limit_r;
  logic                          cfg_hit;
  fat12_pkg::cmd_t               cmd;
  fat12_pkg::stat_t              stat;

  // Register port: no wait states
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2] == fat12_pkg::REG_CLUSTER_LIMIT);
  assign prdata  = cfg_hit ? 32'(limit_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= fat12_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      limit_r <= pwdata[fat12_pkg::LIMIT_W-1:0];
    end
  end

  fat12_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_func (in_func),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  fat12_dp #(
    .TABLE_BYTES  (TABLE_BYTES),
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_func           (in_func),
    .in_cluster        (in_cluster),
    .in_value          (in_value),
    .in_byte_address   (in_byte_address),
    .in_byte_data      (in_byte_data),
    .cluster_limit     (limit_r),
    .out_valid         (out_valid),
    .out_next_cluster  (out_next_cluster),
    .out_end_of_chain  (out_end_of_chain),
    .out_found_cluster (out_found_cluster),
    .out_free_count    (out_free_count),
    .out_status        (out_status),
    .out_sector_index  (out_sector_index),
    .out_sector_count  (out_sector_count)
  );

  // A result only follows a cycle of work
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a preceding busy cycle");

  // Strobes never run back to back
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // Disk full reports no cluster
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_found_cluster == '0))
    else $error("disk full with a nonzero found cluster");

  // End of chain always reports the end code
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_end_of_chain) |-> (out_next_cluster == fat12_pkg::EOC_CODE))
    else $error("end of chain without the end code");

endmodule

// ===== rtl/core/fat12_ram.sv =====
// Generic RAM with one write port and two registered read ports.
module fat12_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read ports
  always_ff @(posedge clk) begin
    rdata_a <= mem_r[raddr_a];
    rdata_b <= mem_r[raddr_b];
  end

endmodule

// ===== rtl/core/fat12_dp.sv =====
// Datapath: table memory, entry decode and merge, scan pipeline, result registers.
module fat12_dp #(
  parameter int TABLE_BYTES  = fat12_pkg::TABLE_BYTES_DEF,
  parameter int SECTOR_BYTES = fat12_pkg::SECTOR_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fat12_pkg::cmd_t                   cmd,
  output fat12_pkg::stat_t                  stat,
  input  logic [fat12_pkg::FUNC_W-1:0]      in_func,
  input  logic [fat12_pkg::ENTRY_W-1:0]     in_cluster,
  input  logic [fat12_pkg::ENTRY_W-1:0]     in_value,
  input  logic [fat12_pkg::BADDR_W-1:0]     in_byte_address,
  input  logic [7:0]                        in_byte_data,
  input  logic [fat12_pkg::LIMIT_W-1:0]     cluster_limit,
  output logic                              out_valid,
  output logic [fat12_pkg::ENTRY_W-1:0]     out_next_cluster,
  output logic                              out_end_of_chain,
  output logic [fat12_pkg::ENTRY_W-1:0]     out_found_cluster,
  output logic [fat12_pkg::COUNT_W-1:0]     out_free_count,
  output logic                              out_status,
  output logic [3:0]                        out_sector_index,
  output logic [1:0]                        out_sector_count
);

  localparam int AW  = $clog2(TABLE_BYTES);
  localparam int OW  = fat12_pkg::BADDR_W;
  // Reciprocal for the sector divide: exact for every OW-bit offset
  localparam int RS  = OW + $clog2(SECTOR_BYTES);
  localparam int RM  = ((1 << RS) + SECTOR_BYTES - 1) / SECTOR_BYTES;
  localparam int MW  = OW + 2;
  localparam int PW  = OW + MW;

  function automatic logic [fat12_pkg::ENTRY_W-1:0] entry_of(
    input logic [7:0] lo,
    input logic [7:0] hi,
    input logic       odd
  );
    entry_of = odd ? {hi, lo[7:4]} : {hi[3:0], lo};
  endfunction

  function automatic logic [OW-1:0] offset_of(input logic [fat12_pkg::ENTRY_W-1:0] c);
    logic [OW:0] triple;
    triple = (OW+1)'(c) + ((OW+1)'(c) << 1);
    offset_of = triple[OW:1];
  endfunction

  logic [fat12_pkg::FUNC_W-1:0]  func_r;
  logic [fat12_pkg::ENTRY_W-1:0] value_r;
  logic [OW-1:0]                 baddr_r;
  logic [7:0]                    bdata_r;
  logic [OW-1:0]                 off_r;
  logic                          odd_r;
  logic [fat12_pkg::LIMIT_W-1:0] idx_r;
  logic                          pv_r;
  logic [fat12_pkg::ENTRY_W-1:0] pidx_r;
  logic [fat12_pkg::COUNT_W-1:0] cnt_r;
  logic [7:0]                    nhi_r;
  logic [OW-1:0]                 qa_r;
  logic [OW-1:0]                 qb_r;

  logic [7:0]                    rd_a;
  logic [7:0]                    rd_b;
  logic [OW-1:0]                 rd_off;
  logic [OW-1:0]                 scan_off;
  logic [fat12_pkg::LIMIT_W-1:0] end_lim;
  logic                          issue_ok;
  logic                          ent_odd;
  logic [fat12_pkg::ENTRY_W-1:0] entry;
  logic                          entry_free;
  logic [7:0]                    new_lo;
  logic [7:0]                    new_hi;
  logic                          load_in_range;
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [7:0]                    ram_wdata;
  logic [PW-1:0]                 prod_a;
  logic [PW-1:0]                 prod_b;

  // Scan bounds and read address selection
  assign end_lim  = (cluster_limit > fat12_pkg::INDEX_SPAN) ? fat12_pkg::INDEX_SPAN
                                                            : cluster_limit;
  assign issue_ok = (idx_r < end_lim);
  assign scan_off = offset_of(idx_r[fat12_pkg::ENTRY_W-1:0]);
  assign rd_off   = cmd.scan ? scan_off : off_r;

  // Decode the entry from the two bytes read
  assign ent_odd    = cmd.scan ? pidx_r[0] : odd_r;
  assign entry      = entry_of(rd_a, rd_b, ent_odd);
  assign entry_free = (entry == '0);

  assign stat.hit        = pv_r && entry_free;
  assign stat.scan_empty = !issue_ok && !pv_r;

  // Merge the new value into the shared nibble
  always_comb begin
    if (odd_r) begin
      new_lo = {value_r[3:0], rd_a[3:0]};
      new_hi = value_r[11:4];
    end else begin
      new_lo = value_r[7:0];
      new_hi = {rd_b[7:4], value_r[11:8]};
    end
  end

  // Write port selection
  assign load_in_range = (32'(baddr_r) < 32'(TABLE_BYTES));
  assign ram_we        = (cmd.load_wr && load_in_range) || cmd.wr_lo || cmd.wr_hi;

  always_comb begin
    if (cmd.load_wr) begin
      ram_waddr = AW'(baddr_r);
      ram_wdata = bdata_r;
    end else if (cmd.wr_lo) begin
      ram_waddr = AW'(off_r);
      ram_wdata = new_lo;
    end else begin
      ram_waddr = AW'(off_r) + AW'(1);
      ram_wdata = nhi_r;
    end
  end

  fat12_ram #(
    .WIDTH (8),
    .DEPTH (TABLE_BYTES)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (AW'(rd_off)),
    .rdata_a (rd_a),
    .raddr_b (AW'(rd_off) + AW'(1)),
    .rdata_b (rd_b)
  );

  // Sector quotients of the first byte and the byte after it
  assign prod_a = PW'(off_r) * PW'(RM);
  assign prod_b = (PW'(off_r) + PW'(1)) * PW'(RM);

  always_ff @(posedge clk) begin
    qa_r <= OW'(prod_a >> RS);
    qb_r <= OW'(prod_b >> RS);
  end

  // Latch the item on transfer
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r  <= in_func;
      value_r <= in_value;
      baddr_r <= in_byte_address;
      bdata_r <= in_byte_data;
      off_r   <= offset_of(in_cluster);
      odd_r   <= in_cluster[0];
    end
    if (cmd.wr_lo) begin
      nhi_r <= new_hi;
    end
  end

  // Scan pipeline: issue one entry a cycle, evaluate it in the next cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (cmd.capture) begin
      pv_r <= 1'b0;
    end else if (cmd.scan) begin
      pv_r <= issue_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_r <= fat12_pkg::LIMIT_W'(2);
      cnt_r <= '0;
    end else if (cmd.scan) begin
      if (issue_ok) begin
        idx_r  <= idx_r + fat12_pkg::LIMIT_W'(1);
        pidx_r <= idx_r[fat12_pkg::ENTRY_W-1:0];
      end
      if (pv_r && entry_free) begin
        cnt_r <= cnt_r + fat12_pkg::COUNT_W'(1);
      end
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.done;
    end
  end

  // Result fields
  always_ff @(posedge clk) begin
    if (cmd.done) begin
      out_next_cluster  <= '0;
      out_end_of_chain  <= 1'b0;
      out_found_cluster <= '0;
      out_free_count    <= '0;
      out_status        <= 1'b0;
      out_sector_index  <= '0;
      out_sector_count  <= '0;
      case (func_r)
        fat12_pkg::FUNC_READ: begin
          if (entry >= fat12_pkg::EOC_LOW) begin
            out_next_cluster <= fat12_pkg::EOC_CODE;
            out_end_of_chain <= 1'b1;
          end else begin
            out_next_cluster <= entry;
          end
        end
        fat12_pkg::FUNC_WRITE: begin
          out_sector_index <= qa_r[3:0];
          out_sector_count <= (qa_r != qb_r) ? 2'd2 : 2'd1;
        end
        fat12_pkg::FUNC_FIND: begin
          if (stat.hit) begin
            out_found_cluster <= pidx_r;
          end else begin
            out_status <= 1'b1;
          end
        end
        fat12_pkg::FUNC_COUNT: begin
          out_free_count <= cnt_r;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/fat12_ctrl.sv =====
// Controller: sequences each operation and issues datapath commands.
module fat12_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [fat12_pkg::FUNC_W-1:0] in_func,
  input  fat12_pkg::stat_t             stat,
  output fat12_pkg::cmd_t              cmd,
  output logic                         busy
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_LOAD    = 4'd1;
  localparam logic [3:0] ST_NOP     = 4'd2;
  localparam logic [3:0] ST_RD_ISS  = 4'd3;
  localparam logic [3:0] ST_RD_DAT  = 4'd4;
  localparam logic [3:0] ST_WR_ISS  = 4'd5;
  localparam logic [3:0] ST_WR_LO   = 4'd6;
  localparam logic [3:0] ST_WR_HI   = 4'd7;
  localparam logic [3:0] ST_SC_FIND = 4'd8;
  localparam logic [3:0] ST_SC_CNT  = 4'd9;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign busy = (state_r != ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          case (in_func)
            fat12_pkg::FUNC_LOAD:  state_nxt = ST_LOAD;
            fat12_pkg::FUNC_READ:  state_nxt = ST_RD_ISS;
            fat12_pkg::FUNC_WRITE: state_nxt = ST_WR_ISS;
            fat12_pkg::FUNC_FIND:  state_nxt = ST_SC_FIND;
            fat12_pkg::FUNC_COUNT: state_nxt = ST_SC_CNT;
            default:               state_nxt = ST_NOP;
          endcase
        end
      end
      ST_LOAD: begin
        cmd.load_wr = 1'b1;
        cmd.done    = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_NOP: begin
        cmd.done  = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_RD_ISS: begin
        state_nxt = ST_RD_DAT;
      end
      ST_RD_DAT: begin
        cmd.done  = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_WR_ISS: begin
        state_nxt = ST_WR_LO;
      end
      ST_WR_LO: begin
        cmd.wr_lo = 1'b1;
        state_nxt = ST_WR_HI;
      end
      ST_WR_HI: begin
        cmd.wr_hi = 1'b1;
        cmd.done  = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SC_FIND: begin
        cmd.scan = 1'b1;
        if (stat.hit || stat.scan_empty) begin
          cmd.done  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_SC_CNT: begin
        cmd.scan = 1'b1;
        if (stat.scan_empty) begin
          cmd.done  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
